@@ design/rgp_pkg.sv @@
// Package for the radial gradient pixel generator.
// Widths, register codes and the bit-search work record. No dependencies.
`default_nettype none
package rgp_pkg;

    localparam int COORD_W  = 12;
    localparam int DIM_W    = 13;
    localparam int MAX_DIM  = 4096;
    localparam int CTR_W    = 12;
    localparam int SQ_W     = 2 * CTR_W;
    localparam int M2_W     = 23;
    localparam int D2_W     = SQ_W + 1;
    localparam int PROD_W   = 38;
    localparam int Q_W      = 30;
    localparam int LEVEL_W  = 8;
    localparam int NUM_CELLS = LEVEL_W;
    localparam int CFG_IDX_W = 1;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;
    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] WIDTH_RST = DIM_W'(640);
    localparam logic [DIM_W-1:0] HEIGHT_RST = DIM_W'(480);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [PROD_W-1:0]  p;
        logic [PROD_W-1:0]  rhs;
        logic [Q_W-1:0]     q;
        logic [M2_W-1:0]    m2;
        logic [LEVEL_W-1:0] k;
        logic               sat;
        logic               zero;
    } rgp_work_t;

endpackage
`default_nettype wire

@@ design/rgp_ifs.sv @@
// Channel interfaces: pixel coordinates in, gray levels out, register writes.
// Depends on rgp_pkg.
`default_nettype none
interface rgp_pixel_if;
    logic                        valid;
    logic                        ready;
    logic [rgp_pkg::COORD_W-1:0] pixel_x;
    logic [rgp_pkg::COORD_W-1:0] pixel_y;
    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface rgp_level_if;
    logic                        valid;
    logic                        ready;
    logic [rgp_pkg::LEVEL_W-1:0] gray_level;
    modport source (output valid, gray_level, input ready);
    modport sink (input valid, gray_level, output ready);
endinterface

interface rgp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rgp_pkg::CFG_IDX_W-1:0] index;
    logic [rgp_pkg::DIM_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/rgp_prep.sv @@
// Front pipeline: center, distances, squares, scaled squared distance.
// Four stages; emits the initial search record. Depends on rgp_pkg.
`default_nettype none
module rgp_prep (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [rgp_pkg::COORD_W-1:0] pixel_x,
    input  wire logic [rgp_pkg::COORD_W-1:0] pixel_y,
    input  wire logic [rgp_pkg::DIM_W-1:0]   image_width,
    input  wire logic [rgp_pkg::DIM_W-1:0]   image_height,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output rgp_pkg::rgp_work_t               out_work
);

    logic [3:0] valid_reg;
    logic [3:0] adv;

    logic [rgp_pkg::DIM_W-1:0] wc, hc;
    logic [rgp_pkg::CTR_W-1:0] cx, cy, dx_next, dy_next, m_next;
    logic [rgp_pkg::CTR_W-1:0] dx_reg, dy_reg, m_reg;
    logic [rgp_pkg::SQ_W-1:0]  dx2_reg, dy2_reg, m_sq;
    logic [rgp_pkg::M2_W-1:0]  m2b_reg, m2c_reg;
    logic [rgp_pkg::D2_W-1:0]  d2_next;
    logic [rgp_pkg::M2_W-1:0]  d2c_reg;
    logic                      satc_reg, zeroc_reg;
    logic [rgp_pkg::PROD_W-1:0] d2w, rhs_next;
    rgp_pkg::rgp_work_t        work_reg;

    assign adv[3] = !valid_reg[3] || out_ready;
    assign adv[2] = !valid_reg[2] || adv[3];
    assign adv[1] = !valid_reg[1] || adv[2];
    assign adv[0] = !valid_reg[0] || adv[1];
    assign in_ready = adv[0];

    always_comb
    begin
        wc = (image_width > rgp_pkg::MAX_DIM_V) ? rgp_pkg::MAX_DIM_V : image_width;
        hc = (image_height > rgp_pkg::MAX_DIM_V) ? rgp_pkg::MAX_DIM_V : image_height;
        cx = wc[rgp_pkg::DIM_W-1:1];
        cy = hc[rgp_pkg::DIM_W-1:1];
        dx_next = (pixel_x >= cx) ? pixel_x - cx : cx - pixel_x;
        dy_next = (pixel_y >= cy) ? pixel_y - cy : cy - pixel_y;
        m_next = (cx < cy) ? cx : cy;
        m_sq = m_reg * m_reg;
        d2_next = {1'b0, dx2_reg} + {1'b0, dy2_reg};
        d2w = {{(rgp_pkg::PROD_W - rgp_pkg::M2_W){1'b0}}, d2c_reg};
        // 65025 = 2^16 - 2^9 + 1
        rhs_next = (d2w << 16) - (d2w << 9) + d2w;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (adv[0]) valid_reg[0] <= in_valid;
            if (adv[1]) valid_reg[1] <= valid_reg[0];
            if (adv[2]) valid_reg[2] <= valid_reg[1];
            if (adv[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            m_reg  <= m_next;
        end
        if (adv[1])
        begin
            dx2_reg <= dx_reg * dx_reg;
            dy2_reg <= dy_reg * dy_reg;
            m2b_reg <= m_sq[rgp_pkg::M2_W-1:0];
        end
        if (adv[2])
        begin
            d2c_reg   <= d2_next[rgp_pkg::M2_W-1:0];
            m2c_reg   <= m2b_reg;
            satc_reg  <= d2_next > {2'b00, m2b_reg};
            zeroc_reg <= m2b_reg == '0;
        end
        if (adv[3])
        begin
            work_reg.p    <= '0;
            work_reg.q    <= '0;
            work_reg.k    <= '0;
            work_reg.rhs  <= rhs_next;
            work_reg.m2   <= m2c_reg;
            work_reg.sat  <= satc_reg;
            work_reg.zero <= zeroc_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign out_work  = work_reg;

endmodule
`default_nettype wire

@@ design/rgp_cell.sv @@
// One cell of the level search: tries one bit of the level.
// Keeps k*k*m2 and k*m2 so the trial needs only shifted adds. Depends on rgp_pkg.
`default_nettype none
module rgp_cell (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [2:0]         bit_pos,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rgp_pkg::rgp_work_t in_work,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output rgp_pkg::rgp_work_t      out_work
);

    logic                       valid_reg;
    rgp_pkg::rgp_work_t         work_reg, work_next;
    logic [rgp_pkg::PROD_W-1:0] q_w, m2_w, trial;
    logic [rgp_pkg::Q_W-1:0]    m2_q;
    logic                       take;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        q_w  = {{(rgp_pkg::PROD_W - rgp_pkg::Q_W){1'b0}}, in_work.q};
        m2_w = {{(rgp_pkg::PROD_W - rgp_pkg::M2_W){1'b0}}, in_work.m2};
        m2_q = {{(rgp_pkg::Q_W - rgp_pkg::M2_W){1'b0}}, in_work.m2};
        // (k + b)^2 m2 = k^2 m2 + 2 b k m2 + b^2 m2
        trial = in_work.p + (q_w << ({1'b0, bit_pos} + 4'd1))
                + (m2_w << {bit_pos, 1'b0});
        take = trial <= in_work.rhs;
        work_next = in_work;
        if (take)
        begin
            work_next.p = trial;
            work_next.q = in_work.q + (m2_q << bit_pos);
            work_next.k = in_work.k | (rgp_pkg::LEVEL_W'(1) << bit_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            work_reg <= work_next;
    end

    assign out_valid = valid_reg;
    assign out_work  = work_reg;

endmodule
`default_nettype wire

@@ design/radial_gradient_pixel_top.sv @@
// Radial gradient pixel generator, top level.
// Depends on rgp_pkg, rgp_ifs, rgp_prep, rgp_cell.
//
// Usage:
//   pixel: coordinate transfers (pixel_x, pixel_y) in; one gray_level
//   transfer comes out on level for each, in order.
//   cfg: register writes, index 0 image_width, index 1 image_height; always
//   ready. Write only while no pixel is in flight; a write takes effect from
//   the cycle after it.
//   Center is (width/2, height/2), radius the smaller of the two; the level
//   is floor(255*sqrt(d2)/radius), 255 at or beyond the radius.
// Path: an input transfer passes through 4 prep stages, 8 search cells and
//   1 output register before its output transfer.
// Throughput: one pixel per clock unless level stalls; every stage and cell
//   is its own register stage, one level bit decided per cell.
// Reset: registers return to 640 x 480, the pipeline empties.
// Stall: a full stage holds while its successor cannot take; bubbles close up,
//   so inputs keep being taken until all 13 stages are full.
`default_nettype none
module radial_gradient_pixel_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rgp_pixel_if.sink   pixel,
    rgp_level_if.source level,
    rgp_cfg_if.sink     cfg
);

    logic [rgp_pkg::DIM_W-1:0] width_reg, height_reg;

    logic                  chain_valid [rgp_pkg::NUM_CELLS+1];
    logic                  chain_ready [rgp_pkg::NUM_CELLS+1];
    rgp_pkg::rgp_work_t    chain_work  [rgp_pkg::NUM_CELLS+1];

    logic                        out_valid_reg;
    logic [rgp_pkg::LEVEL_W-1:0] out_level_reg, level_next;
    rgp_pkg::rgp_work_t          last_work;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= rgp_pkg::WIDTH_RST;
            height_reg <= rgp_pkg::HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            case (rgp_pkg::cfg_reg_t'(cfg.index))
                rgp_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg.data;
                rgp_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    rgp_prep u_prep (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pixel.valid),
        .in_ready     (pixel.ready),
        .pixel_x      (pixel.pixel_x),
        .pixel_y      (pixel.pixel_y),
        .image_width  (width_reg),
        .image_height (height_reg),
        .out_valid    (chain_valid[0]),
        .out_ready    (chain_ready[0]),
        .out_work     (chain_work[0])
    );

    for (genvar i = 0; i < rgp_pkg::NUM_CELLS; i++)
    begin : g_cell
        rgp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .bit_pos   (3'(rgp_pkg::NUM_CELLS - 1 - i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_work   (chain_work[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_work  (chain_work[i+1])
        );
    end

    assign last_work = chain_work[rgp_pkg::NUM_CELLS];
    assign chain_ready[rgp_pkg::NUM_CELLS] = !out_valid_reg || level.ready;

    always_comb
    begin
        if (last_work.sat)
            level_next = rgp_pkg::LEVEL_MAX;
        else if (last_work.zero)
            level_next = '0;
        else
            level_next = last_work.k;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (chain_ready[rgp_pkg::NUM_CELLS])
            out_valid_reg <= chain_valid[rgp_pkg::NUM_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (chain_ready[rgp_pkg::NUM_CELLS] && chain_valid[rgp_pkg::NUM_CELLS])
            out_level_reg <= level_next;
    end

    assign level.valid      = out_valid_reg;
    assign level.gray_level = out_level_reg;

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel.ready |-> (out_valid_reg && !level.ready))
        else $error("input stalled while output side can move");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(chain_valid[rgp_pkg::NUM_CELLS]))
        else $error("result appeared without a finished search");

    a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] |-> (chain_work[0].k == '0 && chain_work[0].p == '0))
        else $error("search record not cleared at chain entry");

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for radial_gradient_pixel_top: coordinate transfers in, gray levels out,
// levels predicted from the current image size. Depends on rgp_pkg, rgp_ifs and the RTL.
`default_nettype none
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES = 80;
    localparam int ITEMS_PER_PHASE = 225;
    localparam int RANDOM_PHASES = 6;

    typedef struct packed {
        logic [rgp_pkg::COORD_W-1:0] x;
        logic [rgp_pkg::COORD_W-1:0] y;
    } coord_t;

    logic clk;
    logic rst_n;

    rgp_pixel_if pixel_ch ();
    rgp_level_if level_ch ();
    rgp_cfg_if   cfg_ch ();

    radial_gradient_pixel_top DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pixel (pixel_ch),
        .level (level_ch),
        .cfg   (cfg_ch)
    );

    coord_t                      coord_backlog[$];
    logic [rgp_pkg::LEVEL_W-1:0] levels_due[$];
    logic [rgp_pkg::DIM_W-1:0]   dim_w;
    logic [rgp_pkg::DIM_W-1:0]   dim_h;
    int                          src_idle_pct;
    int                          sink_idle_pct;
    int                          error_count;
    int                          cycle_count;
    int                          hold_reqs;
    int                          hold_seen;
    int                          stall_left;
    bit                          pixel_taken;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic longint center_of(logic [rgp_pkg::DIM_W-1:0] dim);
        longint d;
        d = (dim > rgp_pkg::MAX_DIM) ? rgp_pkg::MAX_DIM : dim;
        return d / 2;
    endfunction

    function automatic logic [rgp_pkg::LEVEL_W-1:0] radial_level(
        logic [rgp_pkg::COORD_W-1:0] px,
        logic [rgp_pkg::COORD_W-1:0] py);
        longint cx;
        longint cy;
        longint m;
        longint dx;
        longint dy;
        longint d2;
        longint m2;
        longint rhs;
        longint t;
        logic [rgp_pkg::LEVEL_W-1:0] k;
        cx = center_of(dim_w);
        cy = center_of(dim_h);
        m = (cx < cy) ? cx : cy;
        dx = (px >= cx) ? px - cx : cx - px;
        dy = (py >= cy) ? py - cy : cy - py;
        d2 = dx * dx + dy * dy;
        m2 = m * m;
        if (d2 > m2)
            return rgp_pkg::LEVEL_MAX;
        if (m == 0)
            return '0;
        rhs = 65025 * d2;
        k = '0;
        for (int b = rgp_pkg::LEVEL_W - 1; b >= 0; b--)
        begin
            t = k | (1 << b);
            if (t * t * m2 <= rhs)
                k[b] = 1'b1;
        end
        return k;
    endfunction

    // pixel driver
    always @(negedge clk)
    begin
        coord_t nxt;
        if (!rst_n)
            pixel_ch.valid <= 1'b0;
        else if (!pixel_ch.valid || pixel_taken)
        begin
            if (coord_backlog.size() != 0 && $urandom_range(0, 99) >= src_idle_pct)
            begin
                nxt = coord_backlog.pop_front();
                pixel_ch.valid   <= 1'b1;
                pixel_ch.pixel_x <= nxt.x;
                pixel_ch.pixel_y <= nxt.y;
            end
            else
                pixel_ch.valid <= 1'b0;
        end
    end

    // level receiver, with one long hold-off
    always @(negedge clk)
    begin
        if (hold_reqs != hold_seen)
        begin
            stall_left = HOLD_CYCLES;
            hold_seen = hold_reqs;
        end
        if (stall_left != 0)
        begin
            stall_left--;
            level_ch.ready <= 1'b0;
        end
        else
            level_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    // monitor: expectations on input transfer, compare on output transfer
    always @(posedge clk)
    begin
        logic [rgp_pkg::LEVEL_W-1:0] want;
        cycle_count++;
        pixel_taken = rst_n && pixel_ch.valid && pixel_ch.ready;
        if (pixel_taken)
            levels_due.push_back(radial_level(pixel_ch.pixel_x, pixel_ch.pixel_y));
        if (rst_n && level_ch.valid && level_ch.ready)
        begin
            if (levels_due.size() == 0)
            begin
                $error("gray_level transfer with none expected: actual %0d",
                       level_ch.gray_level);
                error_count++;
            end
            else
            begin
                want = levels_due.pop_front();
                if (level_ch.gray_level !== want)
                begin
                    $error("gray_level mismatch: expected %0d, actual %0d",
                           want, level_ch.gray_level);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("Verification failed");
        $finish;
    end

    task automatic add_pixel(int x, int y);
        coord_t c;
        c.x = rgp_pkg::COORD_W'((x < 0) ? 0 : (x > 4095) ? 4095 : x);
        c.y = rgp_pkg::COORD_W'((y < 0) ? 0 : (y > 4095) ? 4095 : y);
        coord_backlog.push_back(c);
    endtask

    task automatic wait_idle();
        while (coord_backlog.size() != 0 || pixel_ch.valid || levels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(rgp_pkg::cfg_reg_t idx, logic [rgp_pkg::DIM_W-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        if (idx == rgp_pkg::REG_IMAGE_WIDTH)
            dim_w = val;
        else
            dim_h = val;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_dims(int w, int h);
        wait_idle();
        write_reg(rgp_pkg::REG_IMAGE_WIDTH, rgp_pkg::DIM_W'(w));
        write_reg(rgp_pkg::REG_IMAGE_HEIGHT, rgp_pkg::DIM_W'(h));
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        int  cx;
        int  cy;
        int  m;
        int  off;
        int  w;
        int  h;
        rst_n = 1'b0;
        pixel_ch.valid = 1'b0;
        pixel_ch.pixel_x = '0;
        pixel_ch.pixel_y = '0;
        level_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = rgp_pkg::REG_IMAGE_WIDTH;
        cfg_ch.data = '0;
        dim_w = rgp_pkg::WIDTH_RST;
        dim_h = rgp_pkg::HEIGHT_RST;
        src_idle_pct = 36;
        sink_idle_pct = 70;
        error_count = 0;
        cycle_count = 0;
        hold_reqs = 0;
        hold_seen = 0;
        stall_left = 0;
        pixel_taken = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset size 640 x 480: center, corners, radius edge
        add_pixel(320, 240);
        add_pixel(0, 0);
        add_pixel(4095, 4095);
        add_pixel(560, 240);
        add_pixel(561, 240);
        add_pixel(321, 240);
        add_pixel(320, 0);
        // zero radius
        set_dims(1, 1);
        add_pixel(0, 0);
        add_pixel(1, 0);
        add_pixel(0, 1);
        // zero width, height above the maximum
        set_dims(0, 8191);
        add_pixel(0, 2048);
        add_pixel(0, 2047);
        // both saturated
        set_dims(8191, 4097);
        add_pixel(2048, 2048);
        add_pixel(0, 0);
        add_pixel(4095, 2048);
        add_pixel(0, 2048);
        add_pixel(4095, 4095);
        add_pixel(2048, 0);
        // radius of one
        set_dims(4096, 2);
        add_pixel(2048, 1);
        add_pixel(2049, 1);
        add_pixel(2049, 2);
        add_pixel(2047, 0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    w = $urandom_range(1, 64);
                    h = $urandom_range(1, 64);
                end
                1:
                begin
                    w = $urandom_range(0, 8191);
                    h = $urandom_range(0, 8191);
                end
                2:
                begin
                    w = 8191;
                    h = $urandom_range(2, 600);
                end
                3:
                begin
                    w = $urandom_range(2, 300);
                    h = $urandom_range(0, 4096);
                end
                4:
                begin
                    w = 4096;
                    h = 4096;
                end
                default:
                begin
                    w = $urandom_range(0, 8191);
                    h = 8191;
                end
            endcase
            wait_idle();
            src_idle_pct  = (ph < 2) ? 36 : (ph < 4) ? 70 : 0;
            sink_idle_pct = (ph < 2) ? 70 : (ph < 4) ? 36 : 0;
            set_dims(w, h);
            cx = int'(center_of(dim_w));
            cy = int'(center_of(dim_h));
            m = (cx < cy) ? cx : cy;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5:
                        add_pixel(cx + int'($urandom_range(0, 2 * m + 2)) - (m + 1),
                                  cy + int'($urandom_range(0, 2 * m + 2)) - (m + 1));
                    6:
                    begin
                        off = m + int'($urandom_range(0, 1));
                        if ($urandom_range(0, 1))
                            off = -off;
                        if ($urandom_range(0, 1))
                            add_pixel(cx + off, cy);
                        else
                            add_pixel(cx, cy + off);
                    end
                    default:
                        add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
                endcase
            end
            if (ph == 4)
                hold_reqs++;
        end

        wait_idle();
        if (levels_due.size() != 0)
        begin
            $error("%0d gray_level transfers never arrived", levels_due.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
`default_nettype wire

@@ radial_gradient_pixel_top.f @@
design/rgp_pkg.sv
design/rgp_ifs.sv
design/rgp_prep.sv
design/rgp_cell.sv
design/radial_gradient_pixel_top.sv
verif/tb.sv
